/* hdl/nrcd_pkg.sv */
// ----------------------------------------------------------------------------
// nrcd_pkg
// Shared types, constants and lookup functions of the RMC clock digit block.
// ----------------------------------------------------------------------------
package nrcd_pkg;

  localparam int FieldLimitDef = 16;
  localparam int QueueDepth    = 2;
  localparam int CfgAddrW      = 3;
  localparam int CfgDataW      = 32;
  localparam int ZoneW         = 4;
  localparam int HdrIdxW       = 3;

  localparam logic [ZoneW-1:0]    ZoneOffsetRst = 4'd4;
  localparam logic [CfgAddrW-1:0] AddrZoneOffset = 3'd0;
  localparam logic [HdrIdxW-1:0]  HdrLast       = 3'd6;
  localparam logic [7:0]          CharComma     = 8'h2C;
  localparam logic [3:0]          DigitRst      = 4'd8;

  typedef enum logic [2:0] {
    ST_HDR   = 3'b001,
    ST_FIELD = 3'b010,
    ST_EMIT  = 3'b100
  } front_state_t;

  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_units;
    logic [3:0] minute_tens;
    logic [3:0] minute_units;
  } digits_t;

  function automatic logic [7:0] hdr_char(input logic [HdrIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = CharComma;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hEB;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hC7;
      4'd3:    s = 8'hE5;
      4'd4:    s = 8'h6C;
      4'd5:    s = 8'hAD;
      4'd6:    s = 8'hAF;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'hED;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

/* hdl/nrcd_front.sv */
// ----------------------------------------------------------------------------
// nrcd_front
// Header match, time field capture and 12-hour conversion; queues emits.
// ----------------------------------------------------------------------------
module nrcd_front #(
  parameter int FIELD_LIMIT = nrcd_pkg::FieldLimitDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [7:0]                  rx_byte,
  input  logic [nrcd_pkg::ZoneW-1:0]  zone_offset,
  output logic                        push,
  output nrcd_pkg::digits_t           push_digits
);

  localparam int CntW = $clog2(FIELD_LIMIT + 1);
  localparam logic [CntW-1:0] CntLimit = CntW'(FIELD_LIMIT);
  localparam logic [CntW-1:0] CntMin   = CntW'(7);
  localparam logic [CntW-1:0] CntKeep  = CntW'(4);

  nrcd_pkg::front_state_t          state_r, state_nxt;
  logic [nrcd_pkg::HdrIdxW-1:0]    idx_r, idx_nxt;
  logic [CntW-1:0]                 cnt_r, cnt_nxt;
  nrcd_pkg::digits_t               digits_r, digits_nxt;
  logic [3:0]                      chars_r [4];
  logic                            char_we;

  logic [7:0] h0, h1, h2, zone8;
  logic [8:0] diff;
  logic       over;
  nrcd_pkg::digits_t conv;

  // 12-hour conversion of the captured field
  always_comb begin
    zone8 = {4'b0, zone_offset};
    h0    = {1'b0, chars_r[0], 3'b0} + {3'b0, chars_r[0], 1'b0} + {4'b0, chars_r[1]};
    h1    = (h0 > 8'd12) ? h0 - 8'd12 : h0;
    h2    = (h1 <= zone8) ? h1 + 8'd12 : h1;
    diff  = {1'b0, h2} - {1'b0, zone8};
    over  = diff[8] || (diff[7:0] > 8'd9);
    conv.hour_tens    = over ? 4'd1 : 4'd0;
    conv.hour_units   = over ? diff[3:0] - 4'd10 : diff[3:0];
    conv.minute_tens  = chars_r[2];
    conv.minute_units = chars_r[3];
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    digits_nxt = digits_r;
    char_we    = 1'b0;
    push       = 1'b0;
    if (acc) begin
      unique case (state_r)
        nrcd_pkg::ST_HDR: begin
          if (rx_byte == nrcd_pkg::hdr_char(idx_r)) begin
            if (idx_r == nrcd_pkg::HdrLast) begin
              state_nxt = nrcd_pkg::ST_FIELD;
              idx_nxt   = '0;
              cnt_nxt   = '0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end else begin
            idx_nxt = '0;
          end
        end
        nrcd_pkg::ST_FIELD: begin
          if (rx_byte == nrcd_pkg::CharComma) begin
            digits_nxt = (cnt_r > CntMin) ? conv : '0;
            cnt_nxt    = '0;
            state_nxt  = nrcd_pkg::ST_EMIT;
          end else if (cnt_r < CntLimit) begin
            char_we = (cnt_r < CntKeep);
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        nrcd_pkg::ST_EMIT: begin
          push      = 1'b1;
          state_nxt = nrcd_pkg::ST_HDR;
          idx_nxt   = '0;
        end
        default: begin
          state_nxt = nrcd_pkg::ST_HDR;
          idx_nxt   = '0;
        end
      endcase
    end
  end

  assign push_digits = digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nrcd_pkg::ST_HDR;
      idx_r    <= '0;
      cnt_r    <= '0;
      digits_r <= {nrcd_pkg::DigitRst, nrcd_pkg::DigitRst,
                   nrcd_pkg::DigitRst, nrcd_pkg::DigitRst};
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      digits_r <= digits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (char_we) begin
      chars_r[cnt_r[1:0]] <= rx_byte[3:0];
    end
  end

endmodule

/* hdl/nrcd_queue.sv */
// ----------------------------------------------------------------------------
// nrcd_queue
// Small register FIFO of digit sets between the parser and the output stage.
// ----------------------------------------------------------------------------
module nrcd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nrcd_pkg::digits_t push_digits,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output nrcd_pkg::digits_t head
);

  localparam int PtrW = (nrcd_pkg::QueueDepth > 1) ? $clog2(nrcd_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(nrcd_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(nrcd_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(nrcd_pkg::QueueDepth);

  nrcd_pkg::digits_t mem_r [nrcd_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CntFull);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrLast) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrLast) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_digits;
    end
  end

endmodule

/* hdl/nrcd_back.sv */
// ----------------------------------------------------------------------------
// nrcd_back
// Output stage: segment decode with leading blank and registered result.
// ----------------------------------------------------------------------------
module nrcd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  nrcd_pkg::digits_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_hour_tens,
  output logic [3:0]        out_hour_units,
  output logic [3:0]        out_minute_tens,
  output logic [3:0]        out_minute_units,
  output logic [7:0]        out_seg_hour_tens,
  output logic [7:0]        out_seg_hour_units,
  output logic [7:0]        out_seg_minute_tens,
  output logic [7:0]        out_seg_minute_units
);

  logic              valid_r, valid_nxt;
  nrcd_pkg::digits_t dig_r;
  logic [7:0]        seg_ht_r, seg_hu_r, seg_mt_r, seg_mu_r;

  assign q_pop     = !q_empty && (!valid_r || !out_stall);
  assign valid_nxt = q_pop || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dig_r    <= q_head;
      seg_ht_r <= (q_head.hour_tens == 4'd0) ? 8'h00
                                              : nrcd_pkg::seg_pattern(q_head.hour_tens);
      seg_hu_r <= nrcd_pkg::seg_pattern(q_head.hour_units);
      seg_mt_r <= nrcd_pkg::seg_pattern(q_head.minute_tens);
      seg_mu_r <= nrcd_pkg::seg_pattern(q_head.minute_units);
    end
  end

  assign out_valid            = valid_r;
  assign out_hour_tens        = dig_r.hour_tens;
  assign out_hour_units       = dig_r.hour_units;
  assign out_minute_tens      = dig_r.minute_tens;
  assign out_minute_units     = dig_r.minute_units;
  assign out_seg_hour_tens    = seg_ht_r;
  assign out_seg_hour_units   = seg_hu_r;
  assign out_seg_minute_tens  = seg_mt_r;
  assign out_seg_minute_units = seg_mu_r;

endmodule

/* hdl/nmea_rmc_clock_digits.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_clock_digits
// RMC sentence time parser producing local 12-hour clock digits and segments.
// ----------------------------------------------------------------------------
// One byte transfer is taken per clock cycle. The input stalls only while the
// two-entry queue between the parser and the output register is full, which
// happens only when the output side stalls. A result follows the byte after
// the time field's closing comma: it is written into the queue when that byte
// is taken and then moves on to the output register. The zone offset register
// sits at byte address 0 of the APB port and resets to 4.
module nmea_rmc_clock_digits #(
  parameter int FIELD_LIMIT = nrcd_pkg::FieldLimitDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_hour_tens,
  output logic [3:0]                    out_hour_units,
  output logic [3:0]                    out_minute_tens,
  output logic [3:0]                    out_minute_units,
  output logic [7:0]                    out_seg_hour_tens,
  output logic [7:0]                    out_seg_hour_units,
  output logic [7:0]                    out_seg_minute_tens,
  output logic [7:0]                    out_seg_minute_units,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrcd_pkg::CfgAddrW-1:0] paddr,
  input  logic [nrcd_pkg::CfgDataW-1:0] pwdata,
  output logic [nrcd_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  logic [nrcd_pkg::ZoneW-1:0] zone_r, zone_nxt;
  logic                       in_acc, push, q_full, q_empty, q_pop;
  nrcd_pkg::digits_t          push_digits, q_head;

  assign pready = 1'b1;

  always_comb begin
    zone_nxt = zone_r;
    if (psel && penable && pwrite && pready && (paddr == nrcd_pkg::AddrZoneOffset)) begin
      zone_nxt = pwdata[nrcd_pkg::ZoneW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == nrcd_pkg::AddrZoneOffset) begin
      prdata[nrcd_pkg::ZoneW-1:0] = zone_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= nrcd_pkg::ZoneOffsetRst;
    end else begin
      zone_r <= zone_nxt;
    end
  end

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  nrcd_front #(
    .FIELD_LIMIT(FIELD_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .rx_byte     (in_rx_byte),
    .zone_offset (zone_r),
    .push        (push),
    .push_digits (push_digits)
  );

  nrcd_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_digits (push_digits),
    .pop         (q_pop),
    .full        (q_full),
    .empty       (q_empty),
    .head        (q_head)
  );

  nrcd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_hour_tens        (out_hour_tens),
    .out_hour_units       (out_hour_units),
    .out_minute_tens      (out_minute_tens),
    .out_minute_units     (out_minute_units),
    .out_seg_hour_tens    (out_seg_hour_tens),
    .out_seg_hour_units   (out_seg_hour_units),
    .out_seg_minute_tens  (out_seg_minute_tens),
    .out_seg_minute_units (out_seg_minute_units)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RMC sentence clock digit parser. Byte streams of
// headers, time fields of every length, broken headers and line noise go in
// under random idling on both sides; each clock face result is predicted in
// the bench and compared field by field. The zone offset is reprogrammed over
// the APB port between phases, including the extremes, and read back.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [3:0] StepIdle     = 4'd0;
  localparam logic [3:0] StepComma    = 4'd6;
  localparam logic [3:0] StepField    = 4'd7;
  localparam logic [3:0] StepEmit     = 4'd8;
  localparam int         FieldMax     = nrcd_pkg::FieldLimitDef;
  localparam logic [3:0] ZoneAtReset  = 4'd4;
  localparam logic [3:0] DigitAtReset = 4'd8;
  localparam int         TargetItems  = 1550;
  localparam int         PhaseItems   = 200;

  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_units;
    logic [3:0] minute_tens;
    logic [3:0] minute_units;
    logic [7:0] seg_hour_tens;
    logic [7:0] seg_hour_units;
    logic [7:0] seg_minute_tens;
    logic [7:0] seg_minute_units;
  } clock_face_t;

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_rx_byte = 8'h00;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [3:0]          out_hour_tens, out_hour_units, out_minute_tens, out_minute_units;
  logic [7:0]          out_seg_hour_tens, out_seg_hour_units;
  logic [7:0]          out_seg_minute_tens, out_seg_minute_units;
  logic                          psel       = 1'b0;
  logic                          penable    = 1'b0;
  logic                          pwrite     = 1'b0;
  logic [nrcd_pkg::CfgAddrW-1:0] paddr      = '0;
  logic [nrcd_pkg::CfgDataW-1:0] pwdata     = '0;
  logic [nrcd_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  // parser mirror
  logic [3:0] step_q;
  logic [4:0] char_cnt;
  logic [7:0] time_chars [4];
  logic [3:0] digit_q [4];
  logic [3:0] zone_now = ZoneAtReset;

  logic [7:0]  byte_backlog [$];
  clock_face_t face_due [$];
  bit          calm = 1'b0;
  int          err_count = 0;

  nmea_rmc_clock_digits u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hour_tens       (out_hour_tens),
    .out_hour_units      (out_hour_units),
    .out_minute_tens     (out_minute_tens),
    .out_minute_units    (out_minute_units),
    .out_seg_hour_tens   (out_seg_hour_tens),
    .out_seg_hour_units  (out_seg_hour_units),
    .out_seg_minute_tens (out_seg_minute_tens),
    .out_seg_minute_units(out_seg_minute_units),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] header_byte(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h24;
      4'd1:    c = 8'h47;
      4'd2:    c = 8'h50;
      4'd3:    c = 8'h52;
      4'd4:    c = 8'h4D;
      4'd5:    c = 8'h43;
      default: c = nrcd_pkg::CharComma;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] segments_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hEB;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hC7;
      4'd3:    s = 8'hE5;
      4'd4:    s = 8'h6C;
      4'd5:    s = 8'hAD;
      4'd6:    s = 8'hAF;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'hED;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    clock_face_t face;
    int unsigned h;
    if (step_q <= StepComma) begin
      if (step_q == StepComma) char_cnt = '0;
      if (b == header_byte(step_q)) step_q = step_q + 4'd1;
      else step_q = StepIdle;
    end else if (step_q == StepField) begin
      if (b == nrcd_pkg::CharComma) begin
        if (char_cnt > 5'd7) begin
          h = time_chars[0][3:0] * 10 + time_chars[1][3:0];
          if (h > 12) h = h - 12;
          if (h <= zone_now) h = h + 12;
          h = h - zone_now;
          if (h > 9) begin
            digit_q[0] = 4'd1;
            h = h - 10;
          end else begin
            digit_q[0] = 4'd0;
          end
          digit_q[1] = h[3:0];
          digit_q[2] = time_chars[2][3:0];
          digit_q[3] = time_chars[3][3:0];
        end else begin
          foreach (digit_q[k]) digit_q[k] = 4'd0;
        end
        char_cnt = '0;
        step_q   = StepEmit;
      end else if (char_cnt < FieldMax) begin
        if (char_cnt < 5'd4) time_chars[char_cnt[1:0]] = b;
        char_cnt = char_cnt + 5'd1;
      end
    end else if (step_q == StepEmit) begin
      face.hour_tens        = digit_q[0];
      face.hour_units       = digit_q[1];
      face.minute_tens      = digit_q[2];
      face.minute_units     = digit_q[3];
      face.seg_hour_tens    = (digit_q[0] == 4'd0) ? 8'h00 : segments_of(digit_q[0]);
      face.seg_hour_units   = segments_of(digit_q[1]);
      face.seg_minute_tens  = segments_of(digit_q[2]);
      face.seg_minute_units = segments_of(digit_q[3]);
      face_due.push_back(face);
      step_q = StepIdle;
    end else begin
      step_q = StepIdle;
    end
  endtask

  // byte driver
  always @(posedge clk) begin : drv
    if (!rst_n) begin
      in_valid <= 1'b0;
      step_q   = StepIdle;
      char_cnt = '0;
      foreach (time_chars[k]) time_chars[k] = 8'h00;
      foreach (digit_q[k]) digit_q[k] = DigitAtReset;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (byte_backlog.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count = err_count + 1;
    end
  endtask

  // result monitor
  always @(posedge clk) begin : mon
    clock_face_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (face_due.size() == 0) begin
        $error("result transfer with nothing expected");
        err_count = err_count + 1;
      end else begin
        want = face_due.pop_front();
        check_field("hour_tens", want.hour_tens, out_hour_tens);
        check_field("hour_units", want.hour_units, out_hour_units);
        check_field("minute_tens", want.minute_tens, out_minute_tens);
        check_field("minute_units", want.minute_units, out_minute_units);
        check_field("seg_hour_tens", want.seg_hour_tens, out_seg_hour_tens);
        check_field("seg_hour_units", want.seg_hour_units, out_seg_hour_units);
        check_field("seg_minute_tens", want.seg_minute_tens, out_seg_minute_tens);
        check_field("seg_minute_units", want.seg_minute_units, out_seg_minute_units);
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 37);
  end

  task automatic write_zone(input logic [3:0] z);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= nrcd_pkg::AddrZoneOffset;
    pwdata  <= {{(nrcd_pkg::CfgDataW-4){1'b0}}, z};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    zone_now = z;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[nrcd_pkg::ZoneW-1:0] !== z) begin
      $error("zone_offset readback: expected %0d, got %0d", z,
             prdata[nrcd_pkg::ZoneW-1:0]);
      err_count = err_count + 1;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_valid || face_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_backlog.push_back(s[i]);
  endtask

  function automatic logic [7:0] field_char(input int pos);
    logic [7:0] c;
    if ($urandom_range(19) == 0) begin
      c = 8'($urandom_range(255));
    end else begin
      case (pos)
        0:       c = ($urandom_range(3) == 0) ? 8'h30 + 8'($urandom_range(9))
                                              : 8'h30 + 8'($urandom_range(2));
        2:       c = 8'h30 + 8'($urandom_range(5));
        6:       c = 8'h2E;
        default: c = 8'h30 + 8'($urandom_range(9));
      endcase
    end
    return c;
  endfunction

  task automatic add_sentence();
    int len;
    int mode;
    mode = $urandom_range(99);
    if (mode < 65) len = $urandom_range(12, 8);
    else if (mode < 82) len = $urandom_range(7);
    else len = $urandom_range(24, 13);
    byte_backlog.push_back(8'h0A);
    for (int i = 0; i < 7; i++) byte_backlog.push_back(header_byte(4'(i)));
    for (int i = 0; i < len; i++) byte_backlog.push_back(field_char(i));
    byte_backlog.push_back(nrcd_pkg::CharComma);
    byte_backlog.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_phase(input int n);
    int mode;
    int cut;
    while (byte_backlog.size() < n) begin
      mode = $urandom_range(99);
      if (mode < 70) begin
        add_sentence();
      end else if (mode < 85) begin
        cut = $urandom_range(6, 1);
        for (int i = 0; i < cut; i++) byte_backlog.push_back(header_byte(4'(i)));
        byte_backlog.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(8, 1)) byte_backlog.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin : main
    int sent;
    int phase;
    logic [3:0] z;
    sent  = 0;
    phase = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // mismatch on the second '$' is not retried, then a full field, then an empty one
    push_text("$$G");
    push_text("$GPRMC,235959.0,");
    byte_backlog.push_back(8'h00);
    push_text("$GPRMC,,");
    byte_backlog.push_back(8'hFF);
    wait_idle();

    while (sent < TargetItems) begin
      case (phase)
        0:       z = 4'd0;
        1:       z = 4'd11;
        2:       z = 4'd15;
        3:       z = 4'd5;
        4:       z = 4'd12;
        5:       z = 4'd1;
        6:       z = 4'd4;
        default: z = 4'($urandom_range(15));
      endcase
      write_zone(z);
      @(negedge clk);
      calm = (phase == 2);
      build_phase(PhaseItems);
      sent = sent + byte_backlog.size();
      wait_idle();
      phase = phase + 1;
    end
    calm = 1'b0;
    wait_idle();

    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
